@@ sv/tdma_sts_pkg.sv @@
// ----------------------------------------------------------------------------
// tdma_sts_pkg
// shared types, register indexes and reset values of the tdma slot scheduler
// ----------------------------------------------------------------------------
`default_nettype none

package tdma_sts_pkg;

  // default number of data slots per period
  localparam int NumSlotsDflt = 12;

  localparam int TickW  = 32;
  localparam int PpcW   = 8;
  localparam int LimitW = 12;
  localparam int CycleW = 13;
  localparam int SeqW   = 8;
  localparam int SlotNumW = 6;
  localparam int CfgIdxW  = 3;

  localparam logic [CycleW-1:0] CycleMax = {CycleW{1'b1}};

  // configuration register reset values
  localparam logic [TickW-1:0]  PeriodTicksRst     = 32'd1356800;
  localparam logic [TickW-1:0]  FirstSlotOffsetRst = 32'd128000;
  localparam logic [TickW-1:0]  SlotSpacingRst     = 32'd70400;
  localparam logic [TickW-1:0]  SwitchOffsetRst    = 32'd1100800;
  localparam logic [PpcW-1:0]   PeriodsPerCycleRst = 8'd6;
  localparam logic [LimitW-1:0] CycleLimitRst      = 12'd2000;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPeriodTicks     = 3'd0,
    CfgFirstSlotOffset = 3'd1,
    CfgSlotSpacing     = 3'd2,
    CfgSwitchOffset    = 3'd3,
    CfgPeriodsPerCycle = 3'd4,
    CfgCycleLimit      = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    EvSync   = 2'd0,
    EvSwitch = 2'd1,
    EvData   = 2'd2
  } event_kind_e;

  // slot start time after reset, wraps modulo 2^32
  function automatic logic [TickW-1:0] slot_start_rst(input int idx);
    logic [TickW-1:0] prod;
    prod = TickW'(idx) * SlotSpacingRst;
    return FirstSlotOffsetRst + prod;
  endfunction

endpackage

`default_nettype wire

@@ sv/tdma_slot_transmit_scheduler_core.sv @@
// ----------------------------------------------------------------------------
// tdma_slot_transmit_scheduler_core
// time-slotted transmit scheduler: sync, data slot and switch events per poll
// ----------------------------------------------------------------------------
// Each transfer on the input channel is a poll carrying the current value of a
// free-running 32-bit tick counter. The block answers each poll with at most
// one event: a sync frame on the first poll and whenever a full period has
// elapsed since the last sync, otherwise a switch-to-sync event once the
// switch offset has passed, otherwise a data frame for the lowest slot that is
// due and not yet sent. Polls that cause nothing are consumed silently, and
// once the cycle number exceeds the limit every later poll is dropped until
// reset. Throughput is one poll per clock while the event channel does not stall;
// each poll passes the input register, then the result register. Start times of
// all slots are kept precomputed in registers that are refreshed by writes to
// the slot offset or spacing registers, so a poll needs only one subtract and
// one compare per slot. Configuration writes land on the next clock and must
// only be issued while no poll is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module tdma_slot_transmit_scheduler_core #(
  parameter int NUM_SLOTS = tdma_sts_pkg::NumSlotsDflt
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration write port
  input  wire logic                                cfg_we_i,
  input  wire logic [tdma_sts_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [tdma_sts_pkg::TickW-1:0]      cfg_wdata_i,
  // poll channel
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [tdma_sts_pkg::TickW-1:0]      now_ticks_i,
  // event channel
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [1:0]                               event_kind_o,
  output logic [tdma_sts_pkg::SeqW-1:0]            frame_seq_o,
  output logic [tdma_sts_pkg::SlotNumW-1:0]        slot_number_o,
  output logic [tdma_sts_pkg::PpcW-1:0]            period_info_o,
  output logic [tdma_sts_pkg::LimitW-1:0]          cycle_number_o,
  output logic                                     run_finished_o
);

  import tdma_sts_pkg::*;

  localparam int SlotIdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // configuration registers
  logic [TickW-1:0]  period_q, first_q, spacing_q, switch_q;
  logic [PpcW-1:0]   ppc_q;
  logic [LimitW-1:0] limit_q;
  // precomputed slot start times
  logic [TickW-1:0]  start_q [NUM_SLOTS];
  logic [TickW-1:0]  start_d [NUM_SLOTS];

  // scheduler state
  logic [TickW-1:0]     last_sync_q, last_sync_d;
  logic                 started_q, started_d;
  logic                 sw_loaded_q, sw_loaded_d;
  logic [PpcW-1:0]      phase_q, phase_d;
  logic [CycleW-1:0]    cycle_q, cycle_d;
  logic [NUM_SLOTS-1:0] done_q, done_d;
  logic [SeqW-1:0]      seq_q, seq_d;
  logic                 finished_q, finished_d;

  // input register
  logic             in_valid_q;
  logic [TickW-1:0] now_q;

  // result register
  logic              out_valid_q;
  event_kind_e       kind_q, kind_d;
  logic [SeqW-1:0]   fseq_q, fseq_d;
  logic [SlotNumW-1:0] slot_q, slot_d;
  logic [PpcW-1:0]   pinfo_q, pinfo_d;
  logic [LimitW-1:0] cnum_q, cnum_d;
  logic              fin_q, fin_d;
  logic              res_valid;

  // handshake
  logic out_free, stage_adv, in_xfer;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign stage_adv  = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------

  // slot i start = first_slot_offset + i * slot_spacing, refreshed on writes
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      start_d[i] = start_q[i];
      if (cfg_we_i && cfg_idx_i == CfgFirstSlotOffset) begin
        start_d[i] = cfg_wdata_i + TickW'(TickW'(i) * spacing_q);
      end else if (cfg_we_i && cfg_idx_i == CfgSlotSpacing) begin
        start_d[i] = first_q + TickW'(TickW'(i) * cfg_wdata_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q  <= PeriodTicksRst;
      first_q   <= FirstSlotOffsetRst;
      spacing_q <= SlotSpacingRst;
      switch_q  <= SwitchOffsetRst;
      ppc_q     <= PeriodsPerCycleRst;
      limit_q   <= CycleLimitRst;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        start_q[i] <= slot_start_rst(i);
      end
    end else begin
      start_q <= start_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CfgPeriodTicks:     period_q  <= cfg_wdata_i;
          CfgFirstSlotOffset: first_q   <= cfg_wdata_i;
          CfgSlotSpacing:     spacing_q <= cfg_wdata_i;
          CfgSwitchOffset:    switch_q  <= cfg_wdata_i;
          CfgPeriodsPerCycle: ppc_q     <= cfg_wdata_i[PpcW-1:0];
          CfgCycleLimit:      limit_q   <= cfg_wdata_i[LimitW-1:0];
          default: ;  // indexes past the register list are ignored
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // input register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_xfer) begin
      in_valid_q <= 1'b1;
    end else if (stage_adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      now_q <= now_ticks_i;
    end
  end

  // --------------------------------------------------------------------------
  // event decision
  // --------------------------------------------------------------------------
  logic [TickW-1:0]     elapsed;
  logic                 do_sync, switch_due, wrap;
  logic [PpcW-1:0]      phase_inc, phase_sync;
  logic [CycleW-1:0]    cycle_sync;
  logic                 run_end;
  logic [NUM_SLOTS-1:0] due, pick_oh;
  logic [SlotIdxW-1:0]  pick_idx;

  // time since last sync, modulo 2^32
  assign elapsed    = now_q - last_sync_q;
  assign do_sync    = !started_q || (elapsed >= period_q);
  assign switch_due = elapsed >= switch_q;

  // period phase and cycle number after a sync; zero periods acts like one
  assign phase_inc  = phase_q + 8'd1;
  assign wrap       = phase_inc >= ppc_q;
  assign phase_sync = (!started_q || wrap) ? '0 : phase_inc;
  assign cycle_sync = (started_q && wrap && cycle_q != CycleMax) ?
                      cycle_q + 13'd1 : cycle_q;
  assign run_end    = cycle_sync > {1'b0, limit_q};

  // slots due and not yet sent; lowest one wins
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      due[i] = !done_q[i] && (elapsed >= start_q[i]);
    end
  end

  assign pick_oh = due & (~due + NUM_SLOTS'(1));

  always_comb begin
    pick_idx = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (pick_oh[i]) begin
        pick_idx = pick_idx | SlotIdxW'(i);
      end
    end
  end

  always_comb begin
    last_sync_d = last_sync_q;
    started_d   = started_q;
    sw_loaded_d = sw_loaded_q;
    phase_d     = phase_q;
    cycle_d     = cycle_q;
    done_d      = done_q;
    seq_d       = seq_q;
    finished_d  = finished_q;

    res_valid = 1'b0;
    kind_d    = EvSync;
    fseq_d    = '0;
    slot_d    = '0;
    pinfo_d   = '0;
    cnum_d    = cycle_q[LimitW-1:0];
    fin_d     = 1'b0;

    priority if (finished_q) begin
      // run over, poll dropped
    end else if (do_sync) begin
      started_d   = 1'b1;
      phase_d     = phase_sync;
      cycle_d     = cycle_sync;
      last_sync_d = now_q;
      done_d      = '0;
      sw_loaded_d = 1'b0;
      res_valid   = 1'b1;
      kind_d      = EvSync;
      fseq_d      = seq_q;
      pinfo_d     = phase_sync + 8'd1;
      cnum_d      = cycle_sync[LimitW-1:0];
      if (run_end) begin
        // final sync keeps the sequence number
        finished_d = 1'b1;
        fin_d      = 1'b1;
      end else begin
        seq_d = seq_q + 8'd1;
      end
    end else if (sw_loaded_q) begin
      // quiet until the next sync
    end else if (switch_due) begin
      sw_loaded_d = 1'b1;
      res_valid   = 1'b1;
      kind_d      = EvSwitch;
    end else if (|due) begin
      done_d    = done_q | pick_oh;
      seq_d     = seq_q + 8'd1;
      res_valid = 1'b1;
      kind_d    = EvData;
      fseq_d    = seq_q;
      slot_d    = SlotNumW'(pick_idx) + 6'd1;
    end
  end

  // state update, one poll per clock while the result register is free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_sync_q <= '0;
      started_q   <= 1'b0;
      sw_loaded_q <= 1'b0;
      phase_q     <= '0;
      cycle_q     <= 13'd1;
      done_q      <= '0;
      seq_q       <= '0;
      finished_q  <= 1'b0;
    end else if (stage_adv) begin
      last_sync_q <= last_sync_d;
      started_q   <= started_d;
      sw_loaded_q <= sw_loaded_d;
      phase_q     <= phase_d;
      cycle_q     <= cycle_d;
      done_q      <= done_d;
      seq_q       <= seq_d;
      finished_q  <= finished_d;
    end
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= stage_adv && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_adv && res_valid) begin
      kind_q  <= kind_d;
      fseq_q  <= fseq_d;
      slot_q  <= slot_d;
      pinfo_q <= pinfo_d;
      cnum_q  <= cnum_d;
      fin_q   <= fin_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_kind_o   = kind_q;
  assign frame_seq_o    = fseq_q;
  assign slot_number_o  = slot_q;
  assign period_info_o  = pinfo_q;
  assign cycle_number_o = cnum_q;
  assign run_finished_o = fin_q;

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the tdma slot transmit scheduler core
// ----------------------------------------------------------------------------
// Polls carrying tick counter values are sent into the block and every event
// that comes out is checked against an in-bench scheduler model that tracks
// the sync time, slot flags, period phase, cycle and sequence numbers. A short
// directed run at the reset settings and at degenerate settings is followed by
// random settings phases that mostly advance the tick count in plausible
// steps, with exact hits on period, switch and slot boundaries and some stray
// tick values. The last phase lowers the cycle limit so the run ends.
// ----------------------------------------------------------------------------

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tdma_sts_pkg::*;

  localparam int NumSlots = NumSlotsDflt;

  // register indexes past the end of the register list, ignored by the block
  localparam logic [CfgIdxW-1:0] CfgIdxSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareHi = 3'd7;

  typedef struct packed {
    event_kind_e         kind;
    logic [SeqW-1:0]     seq;
    logic [SlotNumW-1:0] slot;
    logic [PpcW-1:0]     pinfo;
    logic [LimitW-1:0]   cycle;
    logic                fin;
  } sched_event_t;

  // clock, reset and block inputs, all known from time zero
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i   = '0;
  logic [TickW-1:0]   cfg_wdata_i = '0;
  logic               in_valid_i  = 1'b0;
  logic [TickW-1:0]   now_ticks_i = '0;
  logic               out_stall_i = 1'b0;

  logic                in_stall_o;
  logic                out_valid_o;
  logic [1:0]          event_kind_o;
  logic [SeqW-1:0]     frame_seq_o;
  logic [SlotNumW-1:0] slot_number_o;
  logic [PpcW-1:0]     period_info_o;
  logic [LimitW-1:0]   cycle_number_o;
  logic                run_finished_o;

  // settings as the block holds them
  logic [TickW-1:0]  per_ticks   = PeriodTicksRst;
  logic [TickW-1:0]  slot0_ofs   = FirstSlotOffsetRst;
  logic [TickW-1:0]  slot_gap    = SlotSpacingRst;
  logic [TickW-1:0]  switch_ofs  = SwitchOffsetRst;
  logic [PpcW-1:0]   cyc_periods = PeriodsPerCycleRst;
  logic [LimitW-1:0] cyc_limit   = CycleLimitRst;

  // scheduler state as it should be after each accepted poll
  logic [TickW-1:0]    last_sync  = '0;
  logic                synced     = 1'b0;
  logic                switched   = 1'b0;
  logic [PpcW-1:0]     phase_pos  = '0;
  logic [CycleW-1:0]   cycle_cnt  = CycleW'(1);
  logic [NumSlots-1:0] slots_sent = '0;
  logic [SeqW-1:0]     seq_num    = '0;
  logic                run_done   = 1'b0;

  logic [TickW-1:0] poll_ticks_q[$];
  sched_event_t     pending_events[$];

  // poll generator: running tick count, where it thinks the last sync was
  logic [TickW-1:0] gen_now    = '0;
  logic [TickW-1:0] gen_sync   = '0;
  logic             gen_synced = 1'b0;
  logic [TickW-1:0] stride_max = '0;

  int send_gap_pct   = 38;
  int recv_stall_pct = 70;
  int mismatches     = 0;

  always #1 clk_i = ~clk_i;

  tdma_slot_transmit_scheduler_core #(
    .NUM_SLOTS(NumSlots)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .now_ticks_i   (now_ticks_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .event_kind_o  (event_kind_o),
    .frame_seq_o   (frame_seq_o),
    .slot_number_o (slot_number_o),
    .period_info_o (period_info_o),
    .cycle_number_o(cycle_number_o),
    .run_finished_o(run_finished_o)
  );

  // one poll through the scheduler; returns 1 when it causes an event
  function automatic bit schedule_poll(input logic [TickW-1:0] ticks,
                                       output sched_event_t ev);
    logic [TickW-1:0] elapsed;
    logic [TickW-1:0] start;
    int i;
    ev = '0;
    // after the run has ended every poll is dropped
    if (run_done) return 1'b0;
    elapsed = ticks - last_sync;
    // first poll ever, or a full period since the last sync
    if (!synced || elapsed >= per_ticks) begin
      ev.seq = seq_num;
      if (!synced) begin
        synced = 1'b1;
        phase_pos = '0;
      end else begin
        phase_pos = phase_pos + 8'd1;
        // cycle boundary, zero periods per cycle behaves like one
        if (phase_pos >= cyc_periods) begin
          phase_pos = '0;
          if (cycle_cnt != CycleMax) cycle_cnt = cycle_cnt + 1'b1;
        end
      end
      last_sync = ticks;
      slots_sent = '0;
      switched = 1'b0;
      ev.kind = EvSync;
      ev.pinfo = phase_pos + 8'd1;
      ev.cycle = cycle_cnt[LimitW-1:0];
      // run end: sequence number stays where it is
      if (cycle_cnt > cyc_limit) begin
        run_done = 1'b1;
        ev.fin = 1'b1;
      end else begin
        seq_num = seq_num + 1'b1;
      end
      return 1'b1;
    end
    if (switched) return 1'b0;
    // switch back to sync setup wins over any slot still due
    if (elapsed >= switch_ofs) begin
      switched = 1'b1;
      ev.kind = EvSwitch;
      ev.cycle = cycle_cnt[LimitW-1:0];
      return 1'b1;
    end
    // lowest slot that is due and not yet sent, start wraps mod 2^32
    for (i = 0; i < NumSlots; i++) begin
      start = slot0_ofs + TickW'(i) * slot_gap;
      if (!slots_sent[i] && elapsed >= start) begin
        slots_sent[i] = 1'b1;
        ev.kind = EvData;
        ev.seq = seq_num;
        ev.slot = SlotNumW'(i + 1);
        ev.cycle = cycle_cnt[LimitW-1:0];
        seq_num = seq_num + 1'b1;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic string event_str(input sched_event_t ev);
    return $sformatf("kind=%0d seq=%0d slot=%0d period=%0d cycle=%0d fin=%0b",
                     ev.kind, ev.seq, ev.slot, ev.pinfo, ev.cycle, ev.fin);
  endfunction

  // poll driver: model update at each accepted transfer, then next poll
  always @(posedge clk_i) begin : poll_driver
    sched_event_t ev;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (schedule_poll(now_ticks_i, ev)) pending_events.push_back(ev);
      end
      // a held poll stays put until it is taken
      if (!in_valid_i || !in_stall_o) begin
        if (poll_ticks_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_valid_i  <= 1'b1;
          now_ticks_i <= poll_ticks_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // event monitor: each accepted transfer against the oldest expected event
  always @(posedge clk_i) begin : event_monitor
    sched_event_t got;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.kind  = event_kind_e'(event_kind_o);
        got.seq   = frame_seq_o;
        got.slot  = slot_number_o;
        got.pinfo = period_info_o;
        got.cycle = cycle_number_o;
        got.fin   = run_finished_o;
        if (pending_events.size() == 0 || got !== pending_events[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: event mismatch: expected %s, got %s", $realtime,
                     pending_events.size() != 0 ? event_str(pending_events[0]) : "none",
                     event_str(got));
        end
        if (pending_events.size() != 0) void'(pending_events.pop_front());
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TickW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CfgPeriodTicks:     per_ticks   = data;
      CfgFirstSlotOffset: slot0_ofs   = data;
      CfgSlotSpacing:     slot_gap    = data;
      CfgSwitchOffset:    switch_ofs  = data;
      CfgPeriodsPerCycle: cyc_periods = data[PpcW-1:0];
      CfgCycleLimit:      cyc_limit   = data[LimitW-1:0];
      default: ;
    endcase
  endtask

  // full register set; narrow registers get junk in the unused upper bits
  task automatic apply_settings(input logic [TickW-1:0] period, input logic [TickW-1:0] first,
                                input logic [TickW-1:0] spacing, input logic [TickW-1:0] sw,
                                input logic [PpcW-1:0] ppc, input logic [LimitW-1:0] limit);
    write_reg(CfgPeriodTicks, period);
    write_reg(CfgFirstSlotOffset, first);
    write_reg(CfgSlotSpacing, spacing);
    write_reg(CfgSwitchOffset, sw);
    write_reg(CfgPeriodsPerCycle, ($urandom << PpcW) | TickW'(ppc));
    write_reg(CfgCycleLimit, ($urandom << LimitW) | TickW'(limit));
    write_reg($urandom_range(1) ? CfgIdxSpareHi : CfgIdxSpareLo, $urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    // let precomputed slot starts settle before the next poll
    repeat (4) @(posedge clk_i);
  endtask

  // mostly advancing tick counts, some exact boundary hits, a few stray values
  task automatic queue_polls(input int count);
    logic [TickW-1:0] t;
    logic [TickW-1:0] tgt;
    bit stray;
    repeat (count) begin
      stray = 1'b0;
      case ($urandom_range(19))
        0: begin
          t = $urandom;
          stray = 1'b1;
        end
        1, 2: t = gen_now;
        3, 4, 5: begin
          case ($urandom_range(5))
            0:       tgt = per_ticks - 1;
            1:       tgt = per_ticks;
            2:       tgt = switch_ofs - 1;
            3:       tgt = switch_ofs;
            4:       tgt = slot0_ofs + TickW'($urandom_range(NumSlots - 1)) * slot_gap;
            default: tgt = slot0_ofs + TickW'($urandom_range(NumSlots - 1)) * slot_gap - 1;
          endcase
          t = gen_sync + tgt;
        end
        default: t = gen_now + $urandom_range(stride_max);
      endcase
      if (!gen_synced || t - gen_sync >= per_ticks) begin
        gen_sync = t;
        gen_synced = 1'b1;
      end
      if (!stray) gen_now = t;
      poll_ticks_q.push_back(t);
    end
  endtask

  // block idle: no poll waiting, nothing expected, pipeline drained
  task automatic wait_quiet();
    do @(posedge clk_i);
    while (poll_ticks_q.size() != 0 || in_valid_i || pending_events.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [TickW-1:0] per;
    logic [TickW-1:0] fst;
    logic [TickW-1:0] spc;
    logic [TickW-1:0] sw;
    logic [PpcW-1:0]  ppc;
    int p;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset settings: first poll syncs, slots one and two, switch, quiet polls,
    // one tick short of the period and on it (sync), then tick count extremes
    poll_ticks_q = {32'd1000, 32'd1000, 32'd129000, 32'd129000, 32'd199400,
                    32'd1101800, 32'd1101800, 32'd1357799, 32'd1357800,
                    32'hFFFF_FFFF, 32'd0};
    wait_quiet();

    // zero spacing puts every slot due at once, zero periods per cycle
    apply_settings(32'd1, 32'd0, 32'd0, 32'hFFFF_FFFF, 8'd0, 12'd4094);
    repeat (14) poll_ticks_q.push_back(32'd50);
    poll_ticks_q.push_back(32'd51);
    wait_quiet();
    gen_now = 32'd51;
    gen_sync = 32'd51;
    gen_synced = 1'b1;

    for (p = 0; p < 9; p++) begin
      if (p == 3) begin
        send_gap_pct = 70;
        recv_stall_pct = 38;
      end
      if (p == 6) begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
      per = $urandom_range(200000, 2000);
      fst = $urandom_range(per / 4);
      spc = $urandom_range(per / 16);
      sw  = $urandom_range(per, per / 2);
      ppc = PpcW'($urandom_range(8, 1));
      stride_max = per / 6;
      case (p % 5)
        1: begin
          // all-ones settings, slot starts wrap just below the period
          per = '1;
          fst = '1;
          spc = '1;
          sw  = '1;
          ppc = 8'd255;
          stride_max = 32'h0FFF_FFFF;
        end
        2: begin
          // tiny period, frequent cycle wraps
          per = $urandom_range(64, 1);
          fst = $urandom_range(8);
          spc = $urandom_range(4);
          sw  = $urandom_range(64);
          ppc = PpcW'($urandom_range(3));
          stride_max = per;
        end
        3: begin
          // switch right after sync, no data frames
          sw  = '0;
          ppc = 8'd1;
        end
        4: begin
          // switch never reached, arbitrary slot starts
          fst = $urandom;
          spc = $urandom;
          sw  = per + 1;
          ppc = PpcW'($urandom_range(255, 1));
        end
        default: ;
      endcase
      apply_settings(per, fst, spc, sw, ppc, 12'd4094);
      queue_polls(140);
      wait_quiet();
    end

    // run end: limit at the current cycle, the next cycle wrap finishes it
    stride_max = 32'd400;
    apply_settings(32'd1000, 32'd100, 32'd50, 32'd800, 8'd2, cycle_cnt[LimitW-1:0]);
    queue_polls(60);
    wait_quiet();

    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin : watchdog
    #400000;
    $display("tb_top failed");
    $finish;
  end

endmodule
